// File: rtl/dmcs_pkg.sv
package dmcs_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int MAX_RADIUS_DEF = 15;

    // signed room for centre plus offset and for the clamp limits
    localparam int COORD_W = 11;

    localparam int PC_W       = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISC_RADIUS  = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [PC_W-1:0] STEP_IDLE      = 4'd0;
    localparam logic [PC_W-1:0] STEP_WALK      = 4'd1;
    localparam logic [PC_W-1:0] STEP_DRAIN     = 4'd2;
    localparam logic [PC_W-1:0] STEP_DIV0      = 4'd3;
    localparam logic [PC_W-1:0] STEP_DIV0_WAIT = 4'd4;
    localparam logic [PC_W-1:0] STEP_DIV1      = 4'd5;
    localparam logic [PC_W-1:0] STEP_DIV1_WAIT = 4'd6;
    localparam logic [PC_W-1:0] STEP_DIV2      = 4'd7;
    localparam logic [PC_W-1:0] STEP_DIV2_WAIT = 4'd8;
    localparam logic [PC_W-1:0] STEP_FINISH    = 4'd9;

    typedef enum logic [1:0] {
        CH_0,
        CH_1,
        CH_2
    } chan_sel_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_IDLE,
        COND_WALK,
        COND_DIV,
        COND_JUMP
    } cond_t;

    typedef struct packed {
        logic            accept;
        logic            walk;
        logic            div_start;
        logic            store_q;
        logic            out_strobe;
        chan_sel_t       sel;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic query;
        logic walk_last;
        logic div_busy;
    } status_t;

    typedef struct packed {
        logic       command;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] pixel_ch0;
        logic [7:0] pixel_ch1;
        logic [7:0] pixel_ch2;
    } in_item_t;

    typedef struct packed {
        logic [7:0] mean_ch0;
        logic [7:0] mean_ch1;
        logic [7:0] mean_ch2;
    } result_t;

    function automatic ctrl_t microcode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w        = '0;
        w.sel    = CH_0;
        w.cond   = COND_NEXT;
        w.target = STEP_IDLE;
        case (pc)
            STEP_IDLE:
            begin
                w.accept = 1'b1;
                w.cond   = COND_IDLE;
                w.target = STEP_IDLE;
            end
            STEP_WALK:
            begin
                w.walk   = 1'b1;
                w.cond   = COND_WALK;
                w.target = STEP_WALK;
            end
            STEP_DRAIN:
            begin
                w.cond = COND_NEXT;
            end
            STEP_DIV0:
            begin
                w.div_start = 1'b1;
                w.sel       = CH_0;
            end
            STEP_DIV0_WAIT:
            begin
                w.cond   = COND_DIV;
                w.target = STEP_DIV0_WAIT;
            end
            STEP_DIV1:
            begin
                w.store_q   = 1'b1;
                w.div_start = 1'b1;
                w.sel       = CH_0;
            end
            STEP_DIV1_WAIT:
            begin
                w.sel    = CH_1;
                w.cond   = COND_DIV;
                w.target = STEP_DIV1_WAIT;
            end
            STEP_DIV2:
            begin
                w.store_q   = 1'b1;
                w.div_start = 1'b1;
                w.sel       = CH_1;
            end
            STEP_DIV2_WAIT:
            begin
                w.sel    = CH_2;
                w.cond   = COND_DIV;
                w.target = STEP_DIV2_WAIT;
            end
            STEP_FINISH:
            begin
                w.store_q    = 1'b1;
                w.out_strobe = 1'b1;
                w.sel        = CH_2;
                w.cond       = COND_JUMP;
                w.target     = STEP_IDLE;
            end
            default:
            begin
                w.cond   = COND_JUMP;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/disc_mean_color_sampler_top.sv
// Disc mean colour sampler.
// Command channel: an item transfers at a rising edge with start high and busy
// low. A write command (command 0) stores one pixel in that cycle and leaves
// busy low, so writes may follow back to back. A query (command 1) raises busy
// while the sequencer walks the (2r+1) x (2r+1) window, one image memory read
// a cycle, then divides the three channel sums by the disc point count with a
// shared bit-serial divider.
// A query keeps busy high through the window walk and the three divisions, each
// of SUM_W quotient bits, SUM_W = 18 at the default maximum radius. The result
// sits on result with done high for one cycle, in the cycle in which busy falls;
// the receiver cannot stall, and a new command may transfer in that same cycle.
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high;
// index 0 image width, 1 image height, 2 disc radius, others ignored. Write
// only while busy is low.
// Reset clears the sequencer and sets width 256, height 256, radius 8. Image
// memory contents are undefined until written; no clearing pass.
module disc_mean_color_sampler_top #(
    parameter int MAX_WIDTH  = dmcs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dmcs_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = dmcs_pkg::MAX_RADIUS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  dmcs_pkg::in_item_t              in_item,
    output dmcs_pkg::result_t               result,
    output logic                            done,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dmcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dmcs_pkg::CFG_DATA_W-1:0] cfg_data
);

    import dmcs_pkg::*;

    logic [8:0] image_width_reg;
    logic [8:0] image_height_reg;
    logic [3:0] disc_radius_reg;
    ctrl_t      ctrl;
    status_t    status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 9'd256;
            image_height_reg <= 9'd256;
            disc_radius_reg  <= 4'd8;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                REG_DISC_RADIUS:  disc_radius_reg  <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    dmcs_sequencer u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    dmcs_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .start        (start),
        .in_item      (in_item),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .disc_radius  (disc_radius_reg),
        .status       (status),
        .result       (result),
        .done         (done)
    );

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_query_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && in_item.command == CMD_QUERY) |=> busy)
        else $error("query transfer did not start the sequencer");

    a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && in_item.command == CMD_WRITE) |=> (!busy && !done))
        else $error("pixel write disturbed the sequencer");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

// File: rtl/dmcs_divider.sv
module dmcs_divider #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             busy,
    output logic [NUM_W-1:0] quotient
);

    localparam int IW = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic [IW-1:0]    iter_reg, iter_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_sub;
    logic             q_bit;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        rem_sub   = rem_shift - {1'b0, den_reg};
        q_bit     = (rem_shift >= {1'b0, den_reg});
        busy_next = busy_reg;
        iter_next = iter_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = IW'(NUM_W);
            quo_next  = numer;
            rem_next  = '0;
            den_next  = denom;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[NUM_W-2:0], q_bit};
            rem_next  = q_bit ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            iter_next = iter_reg - 1'b1;
            if (iter_reg == IW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/dmcs_datapath.sv
module dmcs_datapath #(
    parameter int MAX_WIDTH  = dmcs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dmcs_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = dmcs_pkg::MAX_RADIUS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dmcs_pkg::ctrl_t    ctrl,
    input  logic               start,
    input  dmcs_pkg::in_item_t in_item,
    input  logic [8:0]         image_width,
    input  logic [8:0]         image_height,
    input  logic [3:0]         disc_radius,
    output dmcs_pkg::status_t  status,
    output dmcs_pkg::result_t  result,
    output logic               done
);

    import dmcs_pkg::*;

    localparam int OFF_W  = $clog2(MAX_RADIUS + 1) + 1;
    localparam int DIST_W = 2 * OFF_W + 1;
    localparam int DIAM   = 2 * MAX_RADIUS + 1;
    localparam int CNT_W  = $clog2(DIAM * DIAM + 1);
    localparam int SUM_W  = CNT_W + 8;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]                cx_reg, cy_reg;
    logic signed [OFF_W-1:0]   r_reg, dx_reg, dy_reg;
    logic [8:0]                wlim_reg, hlim_reg;
    logic                      valid_b_reg;
    logic [23:0]               rd_data_reg;
    logic [SUM_W-1:0]          sum0_reg, sum1_reg, sum2_reg;
    logic [CNT_W-1:0]          count_reg;
    result_t                   result_reg;
    logic                      done_reg;

    logic [23:0]               mem [DEPTH];

    logic [8:0]                w_eff, h_eff;
    logic signed [OFF_W-1:0]   r_eff;
    logic signed [DIST_W-1:0]  dx_ext, dy_ext, r_ext, pt_sq, r_sq;
    logic signed [COORD_W-1:0] xs, ys;
    logic [8:0]                xx, yy;
    logic [AW-1:0]             rd_addr, wr_addr;
    logic                      in_disc, walk_last;
    logic                      take, wr_ok, wr_en, load_query;
    logic [SUM_W-1:0]          div_numer;
    logic                      div_busy;
    logic [SUM_W-1:0]          div_quo;

    always_comb
    begin
        if (image_width == 9'd0)
            w_eff = 9'd1;
        else if (32'(image_width) > MAX_WIDTH)
            w_eff = 9'(MAX_WIDTH);
        else
            w_eff = image_width;
        if (image_height == 9'd0)
            h_eff = 9'd1;
        else if (32'(image_height) > MAX_HEIGHT)
            h_eff = 9'(MAX_HEIGHT);
        else
            h_eff = image_height;
        if (32'(disc_radius) > MAX_RADIUS)
            r_eff = OFF_W'(MAX_RADIUS);
        else
            r_eff = OFF_W'(disc_radius);
    end

    assign take       = ctrl.accept && start;
    assign wr_ok      = (32'(in_item.pos_x) < MAX_WIDTH) && (32'(in_item.pos_y) < MAX_HEIGHT);
    assign wr_en      = take && (in_item.command == CMD_WRITE) && wr_ok;
    assign load_query = take && (in_item.command == CMD_QUERY);
    assign wr_addr    = AW'(32'(in_item.pos_y) * MAX_WIDTH + 32'(in_item.pos_x));

    // window point: disc test, edge clamp, address
    always_comb
    begin
        dx_ext  = DIST_W'(dx_reg);
        dy_ext  = DIST_W'(dy_reg);
        r_ext   = DIST_W'(r_reg);
        pt_sq   = dx_ext * dx_ext + dy_ext * dy_ext;
        r_sq    = r_ext * r_ext;
        in_disc = (pt_sq <= r_sq);
        xs = $signed(COORD_W'(cx_reg)) + COORD_W'(dx_reg);
        ys = $signed(COORD_W'(cy_reg)) + COORD_W'(dy_reg);
        if (xs < 0)
            xx = 9'd0;
        else if (xs > $signed(COORD_W'(wlim_reg)))
            xx = wlim_reg;
        else
            xx = xs[8:0];
        if (ys < 0)
            yy = 9'd0;
        else if (ys > $signed(COORD_W'(hlim_reg)))
            yy = hlim_reg;
        else
            yy = ys[8:0];
        rd_addr   = AW'(32'(yy) * MAX_WIDTH + 32'(xx));
        walk_last = (dx_reg == r_reg) && (dy_reg == r_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {in_item.pixel_ch2, in_item.pixel_ch1, in_item.pixel_ch0};
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_b_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            valid_b_reg <= ctrl.walk && in_disc;
            done_reg    <= ctrl.out_strobe;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_query)
        begin
            cx_reg    <= in_item.pos_x;
            cy_reg    <= in_item.pos_y;
            r_reg     <= r_eff;
            wlim_reg  <= w_eff - 9'd1;
            hlim_reg  <= h_eff - 9'd1;
            dx_reg    <= -r_eff;
            dy_reg    <= -r_eff;
            sum0_reg  <= '0;
            sum1_reg  <= '0;
            sum2_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (ctrl.walk)
            begin
                if (dx_reg == r_reg)
                begin
                    dx_reg <= -r_reg;
                    dy_reg <= dy_reg + 1'b1;
                end
                else
                    dx_reg <= dx_reg + 1'b1;
            end
            if (valid_b_reg)
            begin
                sum0_reg  <= sum0_reg + SUM_W'(rd_data_reg[7:0]);
                sum1_reg  <= sum1_reg + SUM_W'(rd_data_reg[15:8]);
                sum2_reg  <= sum2_reg + SUM_W'(rd_data_reg[23:16]);
                count_reg <= count_reg + 1'b1;
            end
        end
        if (ctrl.store_q)
        begin
            case (ctrl.sel)
                CH_0:    result_reg.mean_ch0 <= div_quo[7:0];
                CH_1:    result_reg.mean_ch1 <= div_quo[7:0];
                CH_2:    result_reg.mean_ch2 <= div_quo[7:0];
                default: result_reg.mean_ch2 <= div_quo[7:0];
            endcase
        end
    end

    always_comb
    begin
        case (ctrl.sel)
            CH_0:    div_numer = sum0_reg;
            CH_1:    div_numer = sum1_reg;
            CH_2:    div_numer = sum2_reg;
            default: div_numer = sum0_reg;
        endcase
    end

    // the channel for the next division is one step ahead of the store
    logic [SUM_W-1:0] div_numer_start;
    always_comb
    begin
        case (ctrl.sel)
            CH_0:    div_numer_start = (ctrl.store_q) ? sum1_reg : sum0_reg;
            CH_1:    div_numer_start = sum2_reg;
            CH_2:    div_numer_start = div_numer;
            default: div_numer_start = div_numer;
        endcase
    end

    dmcs_divider #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .numer    (div_numer_start),
        .denom    (count_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign status.start     = start;
    assign status.query     = (in_item.command == CMD_QUERY);
    assign status.walk_last = walk_last;
    assign status.div_busy  = div_busy;

    assign result = result_reg;
    assign done   = done_reg;

endmodule

// File: rtl/dmcs_sequencer.sv
module dmcs_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  dmcs_pkg::status_t status,
    output dmcs_pkg::ctrl_t   ctrl,
    output logic              busy
);

    import dmcs_pkg::*;

    logic [PC_W-1:0] pc_reg, pc_next;

    always_comb
    begin
        ctrl = microcode(pc_reg);
    end

    always_comb
    begin
        case (ctrl.cond)
            COND_NEXT:
                pc_next = pc_reg + 1'b1;
            COND_IDLE:
                pc_next = (status.start && status.query) ? pc_reg + 1'b1 : ctrl.target;
            COND_WALK:
                pc_next = status.walk_last ? pc_reg + 1'b1 : ctrl.target;
            COND_DIV:
                pc_next = status.div_busy ? ctrl.target : pc_reg + 1'b1;
            COND_JUMP:
                pc_next = ctrl.target;
            default:
                pc_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= STEP_IDLE;
        else
            pc_reg <= pc_next;
    end

    assign busy = (pc_reg != STEP_IDLE);

endmodule

// File: sim/dmcs_mean_checker.sv
`timescale 1ns / 100ps

module dmcs_mean_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  dmcs_pkg::in_item_t              in_item,
    input  dmcs_pkg::result_t               result,
    input  logic                            done,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [dmcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dmcs_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              outstanding,
    output int                              checked
);

    import dmcs_pkg::*;

    logic [23:0] pic [0:MAX_WIDTH_DEF*MAX_HEIGHT_DEF-1];
    logic [8:0]  span_w;
    logic [8:0]  span_h;
    logic [3:0]  radius_cfg;
    result_t     mean_q [$];
    result_t     want;
    int          field_errs;

    function automatic result_t disc_mean(input logic [7:0] cx, input logic [7:0] cy);
        int          w;
        int          h;
        int          r;
        int          dx;
        int          dy;
        int          xx;
        int          yy;
        int unsigned s0;
        int unsigned s1;
        int unsigned s2;
        int unsigned n;
        logic [23:0] px;
        result_t     m;
        w  = (span_w == 0) ? 1 : ((span_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(span_w));
        h  = (span_h == 0) ? 1 : ((span_h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(span_h));
        r  = (radius_cfg > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : int'(radius_cfg);
        s0 = 0;
        s1 = 0;
        s2 = 0;
        n  = 0;
        for (dy = -r; dy <= r; dy++)
        begin
            for (dx = -r; dx <= r; dx++)
            begin
                if (dx * dx + dy * dy <= r * r)
                begin
                    yy = int'(cy) + dy;
                    yy = (yy < 0) ? 0 : ((yy > h - 1) ? h - 1 : yy);
                    xx = int'(cx) + dx;
                    xx = (xx < 0) ? 0 : ((xx > w - 1) ? w - 1 : xx);
                    px = pic[yy * MAX_WIDTH_DEF + xx];
                    s0 += px[7:0];
                    s1 += px[15:8];
                    s2 += px[23:16];
                    n++;
                end
            end
        end
        m.mean_ch0 = 8'(s0 / n);
        m.mean_ch1 = 8'(s1 / n);
        m.mean_ch2 = 8'(s2 / n);
        return m;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            span_w      <= 9'd256;
            span_h      <= 9'd256;
            radius_cfg  <= 4'd8;
            mean_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
            checked     <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  span_w <= cfg_data;
                    REG_IMAGE_HEIGHT: span_h <= cfg_data;
                    REG_DISC_RADIUS:  radius_cfg <= cfg_data[3:0];
                    default:          ;
                endcase
            end
            field_errs = 0;
            if (done)
            begin
                if (mean_q.size() == 0)
                begin
                    $display("%0t: result %h with no query outstanding", $time, result);
                    field_errs = 1;
                end
                else
                begin
                    want = mean_q.pop_front();
                    for (int i = 0; i < 3; i++)
                    begin
                        if (result[23-8*i -: 8] !== want[23-8*i -: 8])
                        begin
                            $display("%0t: mean_ch%0d expected %0d, got %0d", $time, i,
                                     want[23-8*i -: 8], result[23-8*i -: 8]);
                            field_errs++;
                        end
                    end
                    checked <= checked + 1;
                end
            end
            mismatches <= mismatches + field_errs;
            if (start && !busy)
            begin
                if (in_item.command == CMD_QUERY)
                    mean_q = {mean_q, disc_mean(in_item.pos_x, in_item.pos_y)};
                else
                    pic[{in_item.pos_y, in_item.pos_x}] <=
                        {in_item.pixel_ch2, in_item.pixel_ch1, in_item.pixel_ch0};
            end
            outstanding <= mean_q.size();
        end
    end

endmodule

// File: sim/disc_mean_color_sampler_top_tb.sv
`timescale 1ns / 100ps

module disc_mean_color_sampler_top_tb;
    import dmcs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    in_item_t              in_item   = '0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  busy;
    logic                  done;
    logic                  cfg_ready;
    result_t               result;

    int mismatches;
    int outstanding;
    int checked;

    int idle_pct = 0;
    int eff_w    = 256;
    int eff_h    = 256;
    int rad      = 8;
    int n_items  = 0;
    int n_writes = 0;
    int n_cfg    = 0;
    bit loaded [0:MAX_WIDTH_DEF*MAX_HEIGHT_DEF-1];

    disc_mean_color_sampler_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_item   (in_item),
        .result    (result),
        .done      (done),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dmcs_mean_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .in_item     (in_item),
        .result      (result),
        .done        (done),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int edge_clip(input int v, input int lim);
        return (v < 0) ? 0 : ((v > lim - 1) ? lim - 1 : v);
    endfunction

    function automatic int span_of(input logic [8:0] v);
        return (v == 0) ? 1 : ((v > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(v));
    endfunction

    // start is left high after a transfer so that back to back commands need no dip
    task automatic issue(input in_item_t it);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (busy);
        n_items++;
        if (it.command == CMD_WRITE)
            n_writes++;
    endtask

    task automatic put_pixel(input int x, input int y, input logic [7:0] c0,
                             input logic [7:0] c1, input logic [7:0] c2);
        in_item_t it;
        it.command   = CMD_WRITE;
        it.pos_x     = 8'(x);
        it.pos_y     = 8'(y);
        it.pixel_ch0 = c0;
        it.pixel_ch1 = c1;
        it.pixel_ch2 = c2;
        loaded[y * MAX_WIDTH_DEF + x] = 1'b1;
        issue(it);
    endtask

    // fills any unloaded pixel the disc can touch, then asks for the mean
    task automatic query_at(input int cx, input int cy);
        int       xl;
        int       xh;
        int       yl;
        int       yh;
        int       x;
        int       y;
        in_item_t it;
        xl = edge_clip(cx - rad, eff_w);
        xh = edge_clip(cx + rad, eff_w);
        yl = edge_clip(cy - rad, eff_h);
        yh = edge_clip(cy + rad, eff_h);
        for (y = yl; y <= yh; y++)
            for (x = xl; x <= xh; x++)
                if (!loaded[y * MAX_WIDTH_DEF + x])
                    put_pixel(x, y, 8'($urandom), 8'($urandom), 8'($urandom));
        it.command   = CMD_QUERY;
        it.pos_x     = 8'(cx);
        it.pos_y     = 8'(cy);
        it.pixel_ch0 = 8'($urandom);
        it.pixel_ch1 = 8'($urandom);
        it.pixel_ch2 = 8'($urandom);
        issue(it);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_cfg++;
        case (idx)
            REG_IMAGE_WIDTH:  eff_w = span_of(data);
            REG_IMAGE_HEIGHT: eff_h = span_of(data);
            REG_DISC_RADIUS:  rad = int'(data[3:0]);
            default:          ;
        endcase
        @(posedge clk);
    endtask

    task automatic quiesce();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    function automatic int pick_centre(input int span);
        if (span > 32)
            return $urandom_range(1) ? $urandom_range(0, 3) : $urandom_range(252, 255);
        return $urandom_range(1) ? $urandom_range(0, 255) : $urandom_range(0, span - 1);
    endfunction

    initial
    begin
        int ph;
        int steps;
        int x;
        int y;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, image corners
        put_pixel(0, 0, 8'hFF, 8'hFF, 8'hFF);
        put_pixel(8, 8, 8'h00, 8'h00, 8'h00);
        query_at(0, 0);
        query_at(255, 255);

        // zero spans collapse to one pixel, widest disc
        quiesce();
        set_reg(REG_IMAGE_WIDTH, 9'd0);
        set_reg(REG_IMAGE_HEIGHT, 9'd0);
        set_reg(REG_DISC_RADIUS, 9'h00F);
        query_at(200, 17);
        query_at(0, 255);

        // oversize spans saturate, radius field masked to zero
        quiesce();
        set_reg(REG_IMAGE_WIDTH, 9'h1FF);
        set_reg(REG_IMAGE_HEIGHT, 9'd300);
        set_reg(REG_DISC_RADIUS, 9'h1F0);
        query_at(255, 0);
        query_at(128, 128);

        // unknown index, then saturated all-ones and all-zeros images
        quiesce();
        set_reg(REG_UNUSED, 9'h1FF);
        set_reg(REG_IMAGE_WIDTH, 9'd2);
        set_reg(REG_IMAGE_HEIGHT, 9'd2);
        set_reg(REG_DISC_RADIUS, 9'h1F1);
        for (y = 0; y < 2; y++)
            for (x = 0; x < 2; x++)
                put_pixel(x, y, 8'hFF, 8'hFF, 8'hFF);
        query_at(1, 1);
        for (y = 0; y < 2; y++)
            for (x = 0; x < 2; x++)
                put_pixel(x, y, 8'h00, 8'h00, 8'h00);
        query_at(0, 0);
        put_pixel(1, 0, 8'hFF, 8'h80, 8'h01);
        query_at(255, 255);

        for (ph = 0; ph < 8; ph++)
        begin
            quiesce();
            idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 52 : 35);
            set_reg(REG_IMAGE_WIDTH, (ph == 2) ? 9'h1FF :
                    ((ph == 5) ? 9'd0 : 9'($urandom_range(1, 12))));
            set_reg(REG_IMAGE_HEIGHT, (ph == 2) ? 9'd256 : 9'($urandom_range(1, 12)));
            set_reg(REG_DISC_RADIUS, (ph == 2) ? 9'd3 :
                    ((ph == 6) ? 9'h00F : ((ph == 7) ? 9'h1F0 :
                    9'($urandom_range(0, 7) | ($urandom_range(0, 31) << 4)))));
            for (steps = 0; steps < 32; steps++)
            begin
                if ($urandom_range(99) < 20)
                    put_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                              8'($urandom), 8'($urandom), 8'($urandom));
                else
                    query_at(pick_centre(eff_w), pick_centre(eff_h));
            end
        end

        quiesce();
        repeat (1040) @(posedge clk);
        $display("Covered %0d commands: %0d pixel writes, %0d disc means compared,",
                 n_items, n_writes, checked);
        $display("%0d register writes; spans 1..256 incl. out-of-range values, radius 0..15, %s",
                 n_cfg, "sender idle 0/35/52 pct");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
rtl/dmcs_pkg.sv
rtl/dmcs_divider.sv
rtl/dmcs_datapath.sv
rtl/dmcs_sequencer.sv
rtl/disc_mean_color_sampler_top.sv
sim/dmcs_mean_checker.sv
sim/disc_mean_color_sampler_top_tb.sv
